// ===== rtl/smpq_pkg.sv =====
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int PRIO_W   = 8;
  localparam int RANK_W   = PRIO_W + 1;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_TAKE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TAKEN  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // rank of a stop marker, ahead of every ordinary priority
  localparam logic [RANK_W-1:0] RANK_STOP = '0;
  // larger than any stored rank, seeds the minimum search
  localparam logic [RANK_W-1:0] RANK_NONE = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  // one stored entry
  typedef struct packed {
    logic [RANK_W-1:0]   rank;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

// ===== rtl/stable_min_priority_queue.sv =====
`timescale 1ns / 1ps

// Stable bounded min priority queue over one synchronous entry memory.
// Command channel: a beat is taken when start is high and busy is low.
// command 0 offers {priority_req, handle, is_stop}; command 1 takes the
// most urgent entry (stop markers first, then lowest priority, ties in
// arrival order). Every command gives one result beat: done is high for
// exactly one cycle with status, out_handle, out_priority and out_stop.
// The receiver cannot stall; the result must be taken on that cycle.
// An offer, a refused offer and a take on empty give done in the cycle
// after the command beat, and busy stays low. A take with live entries
// scans the memory (one read per cycle through the registered read port)
// and then compacts the entries behind the taken one down one slot
// through the single read and single write port, and done follows the
// cycle it completes. Entries live in slots 0..occ-1 in arrival order,
// so the first minimum found is the oldest of its rank. Reset clears the
// fill count and control state; the memory holds no reset value and its
// read data is never used above the fill count.
module stable_min_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [smpq_pkg::PRIO_W-1:0]    priority_req,
  input  logic [smpq_pkg::HANDLE_W-1:0]  handle,
  input  logic                           is_stop,
  output logic                           done,
  output logic [smpq_pkg::STATUS_W-1:0]  status,
  output logic [smpq_pkg::HANDLE_W-1:0]  out_handle,
  output logic [smpq_pkg::PRIO_W-1:0]    out_priority,
  output logic                           out_stop
);

  import smpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] OCC_FULL = CW'(DEPTH);

  // entry memory
  entry_t mem [DEPTH];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;

  // control and result registers
  state_t state, state_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] cnt, cnt_next;
  logic pend, pend_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] best_idx, best_idx_next;
  logic [RANK_W-1:0] best_rank, best_rank_next;
  logic [HANDLE_W-1:0] best_handle, best_handle_next;
  logic done_next;
  logic [STATUS_W-1:0] status_next;
  logic [HANDLE_W-1:0] out_handle_next;
  logic [PRIO_W-1:0] out_priority_next;
  logic out_stop_next;

  logic accept;
  logic win;
  logic [AW-1:0] data_idx;
  logic [AW-1:0] new_best_idx;
  entry_t offer_entry;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign rd_addr  = cnt[AW-1:0];
  assign data_idx = AW'(cnt - CW'(1));
  assign win      = pend && (rd_data.rank < best_rank);
  assign new_best_idx = win ? data_idx : best_idx;

  // offered entry: stop markers rank zero, others priority plus one
  assign offer_entry.rank   = is_stop ? RANK_STOP : ({1'b0, priority_req} + RANK_W'(1));
  assign offer_entry.handle = is_stop ? '0 : handle;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= '0;
      cnt          <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
      status       <= ST_STORED;
      out_handle   <= '0;
      out_priority <= '0;
      out_stop     <= 1'b0;
    end else begin
      occ          <= occ_next;
      cnt          <= cnt_next;
      pend         <= pend_next;
      done         <= done_next;
      status       <= status_next;
      out_handle   <= out_handle_next;
      out_priority <= out_priority_next;
      out_stop     <= out_stop_next;
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    wr_ptr      <= wr_ptr_next;
    best_idx    <= best_idx_next;
    best_rank   <= best_rank_next;
    best_handle <= best_handle_next;
  end

  // next state, memory access and result beat
  always_comb begin
    state_next        = state;
    occ_next          = occ;
    cnt_next          = cnt;
    pend_next         = pend;
    wr_ptr_next       = wr_ptr;
    best_idx_next     = best_idx;
    best_rank_next    = best_rank;
    best_handle_next  = best_handle;
    done_next         = 1'b0;
    status_next       = status;
    out_handle_next   = out_handle;
    out_priority_next = out_priority;
    out_stop_next     = out_stop;
    mem_we            = 1'b0;
    mem_waddr         = occ[AW-1:0];
    mem_wdata         = offer_entry;

    case (state)
      S_IDLE: begin
        cnt_next       = '0;
        pend_next      = 1'b0;
        best_rank_next = RANK_NONE;
        if (accept) begin
          out_handle_next   = '0;
          out_priority_next = '0;
          out_stop_next     = 1'b0;
          if (command == CMD_OFFER) begin
            done_next = 1'b1;
            if (occ >= OCC_FULL) begin
              status_next = ST_FULL;
            end else begin
              mem_we      = 1'b1;
              occ_next    = occ + CW'(1);
              status_next = ST_STORED;
            end
          end else if (occ == '0) begin
            done_next   = 1'b1;
            status_next = ST_EMPTY;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      // one read per cycle over the live slots, keep the first minimum
      S_SCAN: begin
        if (win) begin
          best_idx_next    = data_idx;
          best_rank_next   = rd_data.rank;
          best_handle_next = rd_data.handle;
        end
        if (cnt < occ) begin
          cnt_next  = cnt + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (pend) begin
            state_next  = S_SHIFT;
            cnt_next    = CW'(new_best_idx) + CW'(1);
            wr_ptr_next = new_best_idx;
          end
        end
      end

      // move later entries down one slot, writing what was read from k into k-1
      S_SHIFT: begin
        if (pend) begin
          mem_we      = 1'b1;
          mem_waddr   = wr_ptr;
          mem_wdata   = rd_data;
          wr_ptr_next = wr_ptr + AW'(1);
        end
        if (cnt < occ) begin
          cnt_next  = cnt + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next  = S_IDLE;
            occ_next    = occ - CW'(1);
            done_next   = 1'b1;
            status_next = ST_TAKEN;
            if (best_rank == RANK_STOP) begin
              out_stop_next     = 1'b1;
              out_handle_next   = '0;
              out_priority_next = '0;
            end else begin
              out_stop_next     = 1'b0;
              out_handle_next   = best_handle;
              out_priority_next = PRIO_W'(best_rank - RANK_W'(1));
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // fill count stays within the store
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_FULL)
    else $error("fill count above depth");

  // a take on a non-empty store starts the search
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_TAKE && occ != '0 |=> busy)
    else $error("take did not start search");

  // a stored offer grows the fill count by one
  a_store_occ: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_STORED && !$past(rst) |-> occ == $past(occ) + CW'(1))
    else $error("stored offer did not grow fill count");

  // a taken entry shrinks the fill count by one
  a_take_occ: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_TAKEN && !$past(rst) |-> occ == $past(occ) - CW'(1))
    else $error("take did not shrink fill count");

  // compaction writes stay below the read pointer
  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT && mem_we |-> CW'(wr_ptr) < cnt)
    else $error("compaction write overtook read");

endmodule

// ===== tb/tb_stable_min_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_stable_min_priority_queue;
  import smpq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int LIMIT       = 4_000_000;
  localparam int SETTLE      = 64;
  localparam int N_RANDOM    = 825;
  localparam int QUIET_ITEMS = 200;

  // one result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic                stop;
  } qres_t;

  // one command beat, with an optional hand-written expectation
  typedef struct packed {
    logic                command;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
    logic                stop;
    logic                fixed;
    qres_t               want;
  } cmd_t;

  localparam qres_t RES_STORED = '{ST_STORED, '0, '0, 1'b0};
  localparam qres_t RES_FULL   = '{ST_FULL, '0, '0, 1'b0};
  localparam qres_t RES_EMPTY  = '{ST_EMPTY, '0, '0, 1'b0};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                command = CMD_OFFER;
  logic [PRIO_W-1:0]   priority_req = '0;
  logic [HANDLE_W-1:0] handle = '0;
  logic                is_stop = 1'b0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [PRIO_W-1:0]   out_priority;
  logic                out_stop;

  // testbench side of the beat: hand-written expectation travels with it
  logic  beat_fixed = 1'b0;
  qres_t beat_want = RES_STORED;

  // mirror of the queue contents
  logic [RANK_W-1:0]   pq_rank[QDEPTH];
  logic [HANDLE_W-1:0] pq_handle[QDEPTH];
  int                  pq_fill = 0;

  qres_t pending_results[$];
  qres_t got_res, want_res;
  int    mismatches = 0;
  int    cycles = 0;
  int    n_beats = 0, n_stored = 0, n_full = 0, n_taken = 0, n_stops = 0, n_empty = 0;

  stable_min_priority_queue #(.DEPTH(QDEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .priority_req (priority_req),
    .handle       (handle),
    .is_stop      (is_stop),
    .done         (done),
    .status       (status),
    .out_handle   (out_handle),
    .out_priority (out_priority),
    .out_stop     (out_stop)
  );

  always #2 clk = ~clk;

  // apply one command to the mirror and return the result it must give
  function automatic qres_t serve_cmd(input logic cmd, input logic [PRIO_W-1:0] p,
                                      input logic [HANDLE_W-1:0] h, input logic stp);
    qres_t               r;
    int                  best;
    logic [RANK_W-1:0]   rk;
    logic [HANDLE_W-1:0] hh;
    r = RES_STORED;
    if (cmd == CMD_OFFER) begin
      if (pq_fill >= QDEPTH) begin
        r = RES_FULL;
      end else begin
        pq_rank[pq_fill]   = stp ? RANK_STOP : {1'b0, p} + RANK_W'(1);
        pq_handle[pq_fill] = stp ? '0 : h;
        pq_fill++;
      end
    end else if (pq_fill == 0) begin
      r = RES_EMPTY;
    end else begin
      // first lowest rank is the oldest of that rank
      best = 0;
      for (int i = 1; i < pq_fill; i++)
        if (pq_rank[i] < pq_rank[best]) best = i;
      rk = pq_rank[best];
      hh = pq_handle[best];
      for (int i = best; i < pq_fill - 1; i++) begin
        pq_rank[i]   = pq_rank[i + 1];
        pq_handle[i] = pq_handle[i + 1];
      end
      pq_fill--;
      r.status = ST_TAKEN;
      if (rk == RANK_STOP) begin
        r.stop = 1'b1;
      end else begin
        r.handle = hh;
        r.prio   = PRIO_W'(rk - RANK_W'(1));
      end
    end
    return r;
  endfunction

  function automatic qres_t taken(input int h, input int p, input logic s);
    return '{ST_TAKEN, HANDLE_W'(h), PRIO_W'(p), s};
  endfunction

  function automatic cmd_t row(input logic c, input int p, input int h, input logic s,
                               input logic f = 1'b0, input qres_t w = RES_STORED);
    return '{c, PRIO_W'(p), HANDLE_W'(h), s, f, w};
  endfunction

  // random beat; mode 0 leans to offers, 1 to takes, 2 is even
  function automatic cmd_t rand_cmd(input int mode);
    cmd_t c;
    int   take_pct;
    int   sel;
    take_pct  = (mode == 0) ? 25 : (mode == 1) ? 75 : 50;
    c.command = ($urandom_range(99) < take_pct) ? CMD_TAKE : CMD_OFFER;
    sel       = $urandom_range(9);
    if (sel < 5)       c.prio = PRIO_W'($urandom_range(3));
    else if (sel < 8)  c.prio = PRIO_W'($urandom_range(255));
    else if (sel == 8) c.prio = '0;
    else               c.prio = '1;
    c.handle = HANDLE_W'($urandom);
    c.stop   = ($urandom_range(99) < 8);
    c.fixed  = 1'b0;
    c.want   = RES_STORED;
    return c;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // drive one beat and hold it until the block takes it
  task automatic issue(input cmd_t c);
    command      <= c.command;
    priority_req <= c.prio;
    handle       <= c.handle;
    is_stop      <= c.stop;
    beat_fixed   <= c.fixed;
    beat_want    <= c.want;
    start        <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // hold off until every result beat has come back
  task automatic drain_pause();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_stable_min_priority_queue: FAIL");
      $finish;
    end
  end

  // predict on each accepted command, check each result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (start === 1'b1 && busy === 1'b0) begin
        got_res = serve_cmd(command, priority_req, handle, is_stop);
        pending_results.push_back(beat_fixed ? beat_want : got_res);
      end
      if (done !== 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no command waiting: status 0x%0h", status);
          mismatches++;
        end else begin
          want_res = pending_results.pop_front();
          compare_field("status", 16'(want_res.status), 16'(status));
          compare_field("out_handle", want_res.handle, out_handle);
          compare_field("out_priority", 16'(want_res.prio), 16'(out_priority));
          compare_field("out_stop", 16'(want_res.stop), 16'(out_stop));
          n_beats++;
          case (want_res.status)
            ST_STORED: n_stored++;
            ST_FULL:   n_full++;
            ST_TAKEN: begin
              n_taken++;
              if (want_res.stop) n_stops++;
            end
            default:   n_empty++;
          endcase
        end
      end
    end
  end

  initial begin
    cmd_t dir_q[$];
    int   mode;
    int   burst;

    // empty take, extremes, stop markers with ignored fields, ties, fill to full,
    // refused offers of both kinds, then stops ahead of everything and ties in order
    dir_q = '{
      row(CMD_TAKE,  0,   16'h0000, 1'b0, 1'b1, RES_EMPTY),
      row(CMD_OFFER, 255, 16'hFFFF, 1'b0, 1'b1, RES_STORED),
      row(CMD_OFFER, 0,   16'h0000, 1'b0, 1'b1, RES_STORED),
      row(CMD_OFFER, 170, 16'h5555, 1'b1, 1'b1, RES_STORED),
      row(CMD_OFFER, 0,   16'h1234, 1'b0, 1'b1, RES_STORED),
      row(CMD_OFFER, 128, 16'h8000, 1'b0),
      row(CMD_OFFER, 127, 16'h7FFF, 1'b0),
      row(CMD_OFFER, 1,   16'h0001, 1'b0),
      row(CMD_OFFER, 254, 16'hFFFE, 1'b0),
      row(CMD_OFFER, 0,   16'hAAAA, 1'b0),
      row(CMD_OFFER, 5,   16'h5A5A, 1'b0),
      row(CMD_OFFER, 5,   16'hA5A5, 1'b0),
      row(CMD_OFFER, 255, 16'hFFFF, 1'b1),
      row(CMD_OFFER, 200, 16'h00FF, 1'b0),
      row(CMD_OFFER, 64,  16'hFF00, 1'b0),
      row(CMD_OFFER, 3,   16'h0F0F, 1'b0),
      row(CMD_OFFER, 3,   16'hF0F0, 1'b0),
      row(CMD_OFFER, 17,  16'hDEAD, 1'b0, 1'b1, RES_FULL),
      row(CMD_OFFER, 0,   16'hBEEF, 1'b1, 1'b1, RES_FULL),
      row(CMD_TAKE,  99,  16'h3C3C, 1'b1, 1'b1, taken(0, 0, 1'b1)),
      row(CMD_TAKE,  0,   16'h0000, 1'b0, 1'b1, taken(0, 0, 1'b1)),
      row(CMD_TAKE,  0,   16'h0000, 1'b0, 1'b1, taken(16'h0000, 0, 1'b0)),
      row(CMD_TAKE,  0,   16'h0000, 1'b0, 1'b1, taken(16'h1234, 0, 1'b0)),
      row(CMD_TAKE,  0,   16'h0000, 1'b0, 1'b1, taken(16'hAAAA, 0, 1'b0)),
      row(CMD_TAKE,  0,   16'h0000, 1'b0)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_q[i]) begin
      maybe_idle(1'b0);
      issue(dir_q[i]);
    end
    drain_pause();

    // random bursts swinging between filling and draining; first stretch never idles
    mode  = 2;
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        mode  = $urandom_range(2);
        burst = $urandom_range(16, 40);
      end
      burst--;
      maybe_idle(n < QUIET_ITEMS);
      issue(rand_cmd(mode));
      if (n == N_RANDOM / 2) drain_pause();
    end

    // let the last take finish, then watch for stray beats
    drain_pause();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d result beats: %0d stored, %0d refused full, %0d taken, %0d empty",
             n_beats, n_stored, n_full, n_taken, n_empty);
    $display("stop markers taken: %0d; full and empty edges, ties served oldest first",
             n_stops);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_stable_min_priority_queue: PASS");
    end else begin
      $display("tb_stable_min_priority_queue: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/smpq_pkg.sv
rtl/stable_min_priority_queue.sv
tb/tb_stable_min_priority_queue.sv
